// ===== hdl/itbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_pkg
// Shared widths, register indexes and job types of the base digit converter.
// ----------------------------------------------------------------------------
package itbd_pkg;

  localparam int RADIX_W        = 9;
  localparam int LIMIT_W        = 6;
  localparam int LIM_W          = LIMIT_W + 1;
  localparam int DIGIT_W        = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 9;
  localparam int DIV_STEPS      = 8;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 31;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(256);

  // per-request settings snapshot taken at acceptance
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [LIM_W-1:0]   limit;
  } job_cfg_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

// ===== hdl/itbd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_if
// Valid/ready channel interfaces: value input, digit output, register write.
// ----------------------------------------------------------------------------
interface itbd_in_if import itbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itbd_out_if import itbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               overflow;
  logic               last;

  modport source (output valid, output digit, output overflow, output last, input ready);
  modport sink   (input valid, input digit, input overflow, input last, output ready);
endinterface

interface itbd_cfg_if import itbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/itbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_front
// Holds the settings registers and turns each accepted request into a job.
// ----------------------------------------------------------------------------
module itbd_front import itbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  itbd_in_if.sink               in_item,
  itbd_cfg_if.sink              cfg_wr,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [VALUE_BITS-1:0] push_value,
  output job_cfg_t              push_cfg
);

  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [LIM_W-1:0]   lim_eff;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    limit_nxt = limit_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_RADIX: radix_nxt = cfg_wr.data[RADIX_W-1:0];
        REG_LIMIT: limit_nxt = cfg_wr.data[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      radix_r <= radix_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = LIM_W'(1);
    end else if ({1'b0, limit_r} > LIM_W'(MAX_DIGITS)) begin
      lim_eff = LIM_W'(MAX_DIGITS);
    end else begin
      lim_eff = {1'b0, limit_r};
    end
  end

  assign in_item.ready  = push_ready;
  assign push_valid     = in_item.valid;
  assign push_value     = in_item.value;
  assign push_cfg.radix = eff_radix(radix_r);
  assign push_cfg.limit = lim_eff;

endmodule

// ===== hdl/itbd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_fifo
// Two-entry job queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
module itbd_fifo import itbd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = ent_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r ^ do_wr;
    rp_nxt  = rp_r ^ do_rd;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/itbd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_div
// Iterative divider by the radix, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module itbd_div import itbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot,
  output logic [DIGIT_W-1:0]    rem
);

  localparam int CYC   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W = CYC * DIV_STEPS;
  localparam int CW    = $clog2(CYC + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] d_r, d_nxt;
  logic [DIV_W-1:0]   dvd_v;
  logic [DIGIT_W-1:0] rem_v;
  logic [RADIX_W-1:0] r2;

  always_comb begin
    rem_v = rem_r;
    dvd_v = dvd_r;
    r2    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r2    = {rem_v, dvd_v[DIV_W-1]};
      dvd_v = {dvd_v[DIV_W-2:0], 1'b0};
      if (r2 >= d_r) begin
        r2       = r2 - d_r;
        dvd_v[0] = 1'b1;
      end
      rem_v = r2[DIGIT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(CYC);
      dvd_nxt  = DIV_W'(dividend);
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      dvd_nxt = dvd_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r[VALUE_BITS-1:0];
  assign rem  = rem_r;

endmodule

// ===== hdl/itbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_back
// Conversion engine: divides out the digits into a buffer, then emits them.
// ----------------------------------------------------------------------------
module itbd_back import itbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  logic [VALUE_BITS-1:0] job_value,
  input  job_cfg_t              job_cfg,
  itbd_out_if.source            out_item
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DSTART = 5'b00010,
    S_DWAIT  = 5'b00100,
    S_RD     = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]    b_r, b_nxt;
  logic [CNT_W-1:0]      lim_r, lim_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      nd_r, nd_nxt;
  logic [CNT_W-1:0]      e_r, e_nxt;
  logic                  too_long_r, too_long_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]    out_digit_r, out_digit_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0]    mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  k_end, e_end, load;

  itbd_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_r),
    .divisor  (b_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign job_ready = (state_r == S_IDLE);
  assign div_start = (state_r == S_DSTART);
  assign k_end     = (CNT_W'(k_r + 1'b1) == lim_r);
  assign e_end     = (CNT_W'(e_r + 1'b1) == lim_r);
  assign load      = (state_r == S_OUT) && (!out_valid_r || out_item.ready);

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    b_nxt         = b_r;
    lim_nxt       = lim_r;
    k_nxt         = k_r;
    nd_nxt        = nd_r;
    e_nxt         = e_r;
    too_long_nxt  = too_long_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_digit_nxt = out_digit_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          q_nxt     = job_value;
          b_nxt     = job_cfg.radix;
          lim_nxt   = CNT_W'(job_cfg.limit);
          k_nxt     = '0;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          q_nxt = div_quot;
          k_nxt = CNT_W'(k_r + 1'b1);
          if (k_end || div_quot == '0) begin
            nd_nxt       = CNT_W'(k_r + 1'b1);
            too_long_nxt = (div_quot != '0);
            e_nxt        = '0;
            state_nxt    = S_RD;
          end else begin
            state_nxt = S_DSTART;
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = (too_long_r || e_r >= nd_r) ? '0 : rd_data_r;
          out_ovf_nxt   = too_long_r;
          out_last_nxt  = e_end;
          e_nxt         = CNT_W'(e_r + 1'b1);
          state_nxt     = e_end ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      e_r         <= '0;
      nd_r        <= '0;
      lim_r       <= CNT_W'(1);
      too_long_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
      nd_r        <= nd_nxt;
      lim_r       <= lim_nxt;
      too_long_r  <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    b_r         <= b_nxt;
    out_digit_r <= out_digit_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (state_r == S_DWAIT && div_done) begin
      mem[k_r[AW-1:0]] <= div_rem;
    end
    rd_data_r <= mem[e_r[AW-1:0]];
  end

  assign out_item.valid    = out_valid_r;
  assign out_item.digit    = out_digit_r;
  assign out_item.overflow = out_ovf_r;
  assign out_item.last     = out_last_r;

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWAIT) |-> (k_r < lim_r))
    else $error("division index past digit limit");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT || state_r == S_RD) |-> (e_r < lim_r && nd_r <= lim_r))
    else $error("emit index past digit limit");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (load && e_end) |=> (state_r == S_IDLE && out_item.last))
    else $error("final digit did not end the request");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DWAIT && !div_done))
    else $error("divider start not followed by wait");

endmodule

// ===== hdl/integer_to_base_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_digits
// Writes a non-negative integer as base-radix digits, least significant first.
//
// channels: in_item carries value; out_item carries digit, overflow and last;
// cfg_wr writes radix (index 0) or digit_limit (index 1), other indexes are
// dropped. cfg_wr is always ready; the user writes it only while the block is
// idle, the block does not enforce it. each request yields exactly digit_limit
// results (limit 0 acts as 1, above MAX_DIGITS as MAX_DIGITS), last set on the
// final one; digits above the top significant one read zero, and a value
// needing more than digit_limit digits gives all-zero digits with overflow set.
// a two-entry queue takes requests while the engine is busy. per request: one
// division per significant digit, up to the limit, by the radix divider
// (S_DSTART, S_DWAIT), then each result is read from the digit buffer (S_RD)
// and offered on out_item (S_OUT).
// reset: radix 10, digit_limit 8, queue and engine empty.
// a stalled receiver holds the current result; the engine waits for it.
// ----------------------------------------------------------------------------
module integer_to_base_digits import itbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  itbd_in_if.sink     in_item,
  itbd_out_if.source  out_item,
  itbd_cfg_if.sink    cfg_wr
);

  localparam int JOB_W = VALUE_BITS + $bits(job_cfg_t);

  logic                  push_valid, push_ready;
  logic [VALUE_BITS-1:0] push_value;
  job_cfg_t              push_cfg;
  logic                  job_valid, job_ready;
  logic [JOB_W-1:0]      job_data;
  logic [VALUE_BITS-1:0] job_value;
  job_cfg_t              job_cfg;

  itbd_front #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_wr     (cfg_wr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_cfg   (push_cfg)
  );

  itbd_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_value, push_cfg}),
    .rd_valid (job_valid),
    .rd_ready (job_ready),
    .rd_data  (job_data)
  );

  assign job_value = job_data[JOB_W-1 -: VALUE_BITS];
  assign job_cfg   = job_cfg_t'(job_data[$bits(job_cfg_t)-1:0]);

  itbd_back #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_value (job_value),
    .job_cfg   (job_cfg),
    .out_item  (out_item)
  );

endmodule
